// ===== hdl/etmq_pkg.sv =====
// Shared types and constants of the epoch tagged message queue.
// Used by the queue cell, the top level and the port checker.
package etmq_pkg;

	localparam int TOW_W  = 30;
	localparam int LEN_W  = 11;
	localparam int ELEN_W = 16;
	localparam int SUM_W  = ELEN_W + 1;
	localparam int OP_W   = 2;
	localparam int ST_W   = 2;
	localparam int ECNT_W = 4;

	localparam logic [ELEN_W-1:0] ELEN_MAX = '1;
	localparam logic [ECNT_W-1:0] ECNT_MAX = '1;

	localparam logic [OP_W-1:0] OP_PART   = 2'd0;
	localparam logic [OP_W-1:0] OP_NEWEST = 2'd1;
	localparam logic [OP_W-1:0] OP_MATCH  = 2'd2;

	localparam logic [ST_W-1:0] ST_ACCEPTED  = 2'd0;
	localparam logic [ST_W-1:0] ST_DISCARDED = 2'd1;
	localparam logic [ST_W-1:0] ST_STALE     = 2'd2;

	// Command broadcast from the control logic to every cell of the chain.
	typedef struct packed {
		logic              clear;
		logic              shift;
		logic [TOW_W-1:0]  load_tow;
		logic [ELEN_W-1:0] load_len;
	} etmq_cmd_t;

endpackage

// ===== hdl/etmq_cell.sv =====
// One slot of the epoch queue: holds a time of week and a length.
// Depends on etmq_pkg for the command structure and field widths.
module etmq_cell import etmq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  etmq_cmd_t         cmd,
	input  logic              load_en,
	input  logic [TOW_W-1:0]  key,
	input  logic [TOW_W-1:0]  nxt_tow,
	input  logic [ELEN_W-1:0] nxt_len,
	output logic [TOW_W-1:0]  tow,
	output logic [ELEN_W-1:0] len,
	output logic              hit
);

	logic [TOW_W-1:0]  tow_q;
	logic [ELEN_W-1:0] len_q;

	// Clearing wins over loading, and loading over taking the neighbour's entry,
	// so the tail cell can be refilled in the same cycle as the queue moves up.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tow_q <= '0;
			len_q <= '0;
		end else if (cmd.clear) begin
			tow_q <= '0;
			len_q <= '0;
		end else if (load_en) begin
			tow_q <= cmd.load_tow;
			len_q <= cmd.load_len;
		end else if (cmd.shift) begin
			tow_q <= nxt_tow;
			len_q <= nxt_len;
		end
	end

	assign tow = tow_q;
	assign len = len_q;
	// An empty slot never matches, even when the key is zero.
	assign hit = (tow_q != '0) && (tow_q == key);

endmodule

// ===== hdl/epoch_tagged_message_queue.sv =====
// Epoch tagged message queue: groups message parts into epochs by time of
// week and keeps the finished epochs in a chain of DEPTH cells, oldest first.
//
// Input channel: in_valid/in_stall with op, msg_tow, msg_len, more_follows.
// Output channel: out_valid/out_stall with found, entry_tow, entry_len,
// pushed, part_status and entry_count; every transaction in gives exactly
// one transaction out.
// A transaction is taken into an input register; a message part, a newest
// request or an unknown op is resolved from there into the output register,
// and one such item per cycle is sustained while the receiver does not stall.
// A match request moves the chain up by one cell per cycle until the wanted
// epoch reaches the head cell, dropping the older epochs in front of it,
// of which there are at most DEPTH - 1.
// While the receiver stalls, the finished result is held in the output
// register and one further transaction is still taken into the input
// register; after that in_stall rises until the result leaves.
// Reset empties every cell, closes the open epoch and drops any pending
// transaction.
module epoch_tagged_message_queue import etmq_pkg::*; #(
	parameter int DEPTH = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [OP_W-1:0]   op,
	input  logic [TOW_W-1:0]  msg_tow,
	input  logic [LEN_W-1:0]  msg_len,
	input  logic              more_follows,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              found,
	output logic [TOW_W-1:0]  entry_tow,
	output logic [ELEN_W-1:0] entry_len,
	output logic              pushed,
	output logic [ST_W-1:0]   part_status,
	output logic [ECNT_W-1:0] entry_count
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	// Input register.
	logic              v_s1;
	logic [OP_W-1:0]   op_s1;
	logic [TOW_W-1:0]  tow_s1;
	logic [LEN_W-1:0]  len_s1;
	logic              more_s1;

	// Open epoch and occupancy.
	logic [TOW_W-1:0]  open_tow_q, open_tow_d;
	logic [ELEN_W-1:0] open_len_q, open_len_d;
	logic [CNT_W-1:0]  count_q, count_d;

	// Output register.
	logic              out_valid_q;
	logic              found_q, pushed_q;
	logic [TOW_W-1:0]  entry_tow_q;
	logic [ELEN_W-1:0] entry_len_q;
	logic [ST_W-1:0]   status_q;
	logic [ECNT_W-1:0] count_out_q;

	// Chain.
	etmq_cmd_t         cmd;
	logic [DEPTH-1:0]  load_en;
	logic [DEPTH-1:0]  hit_vec;
	logic [TOW_W-1:0]  cell_tow [DEPTH];
	logic [ELEN_W-1:0] cell_len [DEPTH];

	// Control.
	logic              out_free, go, done;
	logic              full, tow_nz, open_match, do_load;
	logic [SUM_W-1:0]  sum;
	logic [ELEN_W-1:0] sat_len;
	logic [CNT_W-1:0]  cnt_dec;
	logic [IDX_W-1:0]  load_idx, newest_idx;
	logic              res_found, res_pushed;
	logic [TOW_W-1:0]  res_tow;
	logic [ELEN_W-1:0] res_len;
	logic [ST_W-1:0]   res_status;
	logic [ECNT_W-1:0] res_count;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [TOW_W-1:0]  nxt_tow;
		logic [ELEN_W-1:0] nxt_len;
		if (i == DEPTH - 1) begin : g_tail
			assign nxt_tow = '0;
			assign nxt_len = '0;
		end else begin : g_body
			assign nxt_tow = cell_tow[i+1];
			assign nxt_len = cell_len[i+1];
		end
		etmq_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.load_en (load_en[i]),
			.key     (tow_s1),
			.nxt_tow (nxt_tow),
			.nxt_len (nxt_len),
			.tow     (cell_tow[i]),
			.len     (cell_len[i]),
			.hit     (hit_vec[i])
		);
	end

	assign out_free   = !out_valid_q || !out_stall;
	assign go         = v_s1 && out_free;
	assign full       = (count_q == CNT_W'(DEPTH));
	assign tow_nz     = (tow_s1 != '0);
	assign open_match = (open_tow_q == '0) || (open_tow_q == tow_s1);
	assign sum        = SUM_W'(open_len_q) + SUM_W'(len_s1);
	assign sat_len    = sum[ELEN_W] ? ELEN_MAX : sum[ELEN_W-1:0];
	assign cnt_dec    = count_q - CNT_W'(1);
	assign newest_idx = cnt_dec[IDX_W-1:0];
	assign load_idx   = full ? IDX_W'(DEPTH - 1) : count_q[IDX_W-1:0];

	always_comb begin
		cmd          = '0;
		cmd.load_tow = tow_s1;
		cmd.load_len = sat_len;
		do_load      = 1'b0;
		done         = 1'b0;
		open_tow_d   = open_tow_q;
		open_len_d   = open_len_q;
		count_d      = count_q;
		res_found    = 1'b0;
		res_tow      = '0;
		res_len      = '0;
		res_pushed   = 1'b0;
		res_status   = ST_ACCEPTED;
		if (v_s1) begin
			case (op_s1)
				OP_PART: begin
					done = go;
					if (go) begin
						if (open_match) begin
							if (more_s1) begin
								open_tow_d = tow_s1;
								open_len_d = sat_len;
							end else begin
								// A zero time of week still pushes the oldest
								// epoch out of a full queue but is not stored.
								open_tow_d = '0;
								open_len_d = '0;
								cmd.shift  = full;
								do_load    = tow_nz;
								res_pushed = tow_nz;
								if (full) begin
									count_d = tow_nz ? count_q : cnt_dec;
								end else begin
									count_d = count_q + CNT_W'(tow_nz);
								end
							end
						end else if (open_tow_q < tow_s1) begin
							open_tow_d = '0;
							open_len_d = '0;
							res_status = ST_DISCARDED;
						end else begin
							res_status = ST_STALE;
						end
					end
				end
				OP_NEWEST: begin
					done = go;
					if (go && count_q != '0) begin
						res_found = 1'b1;
						res_tow   = cell_tow[newest_idx];
						res_len   = cell_len[newest_idx];
						cmd.clear = 1'b1;
						count_d   = '0;
					end
				end
				OP_MATCH: begin
					// The chain moves up one cell per cycle until the first
					// matching epoch sits in the head cell.
					if (hit_vec[0]) begin
						done = go;
						if (go) begin
							res_found = 1'b1;
							res_tow   = cell_tow[0];
							res_len   = cell_len[0];
						end
					end else if (|hit_vec) begin
						cmd.shift = 1'b1;
						count_d   = cnt_dec;
					end else begin
						done = go;
					end
				end
				default: begin
					done = go;
				end
			endcase
		end
	end

	always_comb begin
		load_en = '0;
		if (do_load) begin
			load_en[load_idx] = 1'b1;
		end
	end

	always_comb begin
		if (32'(count_d) > 32'(ECNT_MAX)) begin
			res_count = ECNT_MAX;
		end else begin
			res_count = ECNT_W'(count_d);
		end
	end

	assign in_stall = v_s1 && !done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
			open_tow_q  <= '0;
			open_len_q  <= '0;
			count_q     <= '0;
		end else begin
			if (!in_stall) begin
				v_s1 <= in_valid;
			end
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			open_tow_q <= open_tow_d;
			open_len_q <= open_len_d;
			count_q    <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			op_s1   <= op;
			tow_s1  <= msg_tow;
			len_s1  <= msg_len;
			more_s1 <= more_follows;
		end
		if (done) begin
			found_q     <= res_found;
			entry_tow_q <= res_tow;
			entry_len_q <= res_len;
			pushed_q    <= res_pushed;
			status_q    <= res_status;
			count_out_q <= res_count;
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign entry_tow   = entry_tow_q;
	assign entry_len   = entry_len_q;
	assign pushed      = pushed_q;
	assign part_status = status_q;
	assign entry_count = count_out_q;

endmodule

// ===== hdl/etmq_checker.sv =====
// Port level checks of the epoch tagged message queue, bound to the top level.
// Depends on etmq_pkg for field widths and status codes.
module etmq_checker import etmq_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input logic              found,
	input logic [TOW_W-1:0]  entry_tow,
	input logic [ELEN_W-1:0] entry_len,
	input logic              pushed,
	input logic [ST_W-1:0]   part_status,
	input logic [ECNT_W-1:0] entry_count
);

	// A stalled result transaction stays on the port unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(found) && $stable(entry_tow)
			&& $stable(entry_len) && $stable(pushed) && $stable(part_status)
			&& $stable(entry_count))
		else $error("stalled result changed");

	// A returned epoch comes from a request, never from a message part.
	a_found_req: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> !pushed && part_status == ST_ACCEPTED && entry_tow != '0)
		else $error("returned epoch with part flags set");

	// Without a returned epoch the entry fields read as zero.
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> entry_tow == '0 && entry_len == '0)
		else $error("entry fields set without a returned epoch");

	// A pushed epoch occupies a slot afterwards.
	a_push_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pushed |-> entry_count != '0 && part_status == ST_ACCEPTED)
		else $error("push left the queue empty");

endmodule

bind epoch_tagged_message_queue etmq_checker u_etmq_checker (.*);

// ===== verif/epoch_tagged_message_queue_tb.sv =====
// Self-checking testbench for the epoch tagged message queue.
// Depends on etmq_pkg and the epoch_tagged_message_queue top level, which in turn needs etmq_cell.
// A scoreboard class predicts one result per transaction in and checks each result out.
module epoch_tagged_message_queue_tb;
	import etmq_pkg::*;

	localparam int DEPTH = 8;
	localparam int ITEMS = 1750;
	localparam longint TOW_MAX = (64'd1 << TOW_W) - 1;
	localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;
	localparam int PERIOD = 8;
	localparam longint LIMIT_CYCLES = 3_000_000;

	typedef struct packed {
		logic              found;
		logic [TOW_W-1:0]  tow;
		logic [ELEN_W-1:0] len;
		logic              pushed;
		logic [ST_W-1:0]   status;
		logic [ECNT_W-1:0] count;
	} epoch_result_t;

	class epoch_queue_scoreboard;
		logic [TOW_W-1:0]  open_tow = '0;
		logic [ELEN_W-1:0] open_len = '0;
		logic [TOW_W-1:0]  slot_tow [DEPTH];
		logic [ELEN_W-1:0] slot_len [DEPTH];
		epoch_result_t     expected_q [$];
		int errors = 0;
		int accepted = 0;
		int checked = 0;
		int n_pushed = 0;
		int n_found = 0;
		int n_discarded = 0;
		int n_stale = 0;

		function new();
			foreach (slot_tow[i]) begin
				slot_tow[i] = '0;
				slot_len[i] = '0;
			end
		endfunction

		function int occupied();
			int n;
			n = 0;
			foreach (slot_tow[i])
				if (slot_tow[i] != 0)
					n++;
			return n;
		endfunction

		function void drop_oldest();
			for (int i = 1; i < DEPTH; i++) begin
				slot_tow[i-1] = slot_tow[i];
				slot_len[i-1] = slot_len[i];
			end
			slot_tow[DEPTH-1] = '0;
			slot_len[DEPTH-1] = '0;
		endfunction

		function void note_item(logic [OP_W-1:0] op, logic [TOW_W-1:0] tow,
				logic [LEN_W-1:0] len, logic more);
			epoch_result_t r;
			int n;
			int hit;
			logic [SUM_W-1:0] sum;
			r = '0;
			n = occupied();
			accepted++;
			case (op)
				OP_PART: begin
					if (open_tow == 0 || open_tow == tow) begin
						sum = SUM_W'(open_len) + SUM_W'(len);
						open_tow = tow;
						open_len = (sum > ELEN_MAX) ? ELEN_MAX : sum[ELEN_W-1:0];
						if (!more) begin
							if (n == DEPTH) begin
								drop_oldest();
								n = n - 1;
							end
							// An epoch with a zero time would read as an empty slot.
							if (open_tow != 0) begin
								slot_tow[n] = open_tow;
								slot_len[n] = open_len;
								r.pushed = 1'b1;
								n_pushed++;
							end
							open_tow = '0;
							open_len = '0;
						end
					end else if (open_tow < tow) begin
						open_tow = '0;
						open_len = '0;
						r.status = ST_DISCARDED;
						n_discarded++;
					end else begin
						r.status = ST_STALE;
						n_stale++;
					end
				end
				OP_NEWEST: begin
					if (n != 0) begin
						r.found = 1'b1;
						r.tow = slot_tow[n-1];
						r.len = slot_len[n-1];
						n_found++;
						foreach (slot_tow[i]) begin
							slot_tow[i] = '0;
							slot_len[i] = '0;
						end
					end
				end
				OP_MATCH: begin
					hit = -1;
					for (int i = 0; i < n; i++)
						if (hit < 0 && slot_tow[i] == tow)
							hit = i;
					if (hit >= 0) begin
						r.found = 1'b1;
						r.tow = slot_tow[hit];
						r.len = slot_len[hit];
						n_found++;
						repeat (hit) drop_oldest();
					end
				end
				default: ;
			endcase
			n = occupied();
			r.count = (n > ECNT_MAX) ? ECNT_MAX : n[ECNT_W-1:0];
			expected_q.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic found, logic [TOW_W-1:0] tow, logic [ELEN_W-1:0] len,
				logic pushed, logic [ST_W-1:0] status, logic [ECNT_W-1:0] count);
			epoch_result_t want;
			if (expected_q.size() == 0) begin
				$error("Result transaction arrived with nothing expected");
				errors++;
				return;
			end
			want = expected_q.pop_front();
			checked++;
			compare_field("found", 32'(want.found), 32'(found));
			compare_field("entry_tow", 32'(want.tow), 32'(tow));
			compare_field("entry_len", 32'(want.len), 32'(len));
			compare_field("pushed", 32'(want.pushed), 32'(pushed));
			compare_field("part_status", 32'(want.status), 32'(status));
			compare_field("entry_count", 32'(want.count), 32'(count));
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [OP_W-1:0]   op;
	logic [TOW_W-1:0]  msg_tow;
	logic [LEN_W-1:0]  msg_len;
	logic              more_follows;
	logic              out_valid;
	logic              out_stall;
	logic              found;
	logic [TOW_W-1:0]  entry_tow;
	logic [ELEN_W-1:0] entry_len;
	logic              pushed;
	logic [ST_W-1:0]   part_status;
	logic [ECNT_W-1:0] entry_count;

	epoch_queue_scoreboard sb = new();
	int send_pct = 0;
	longint cur_tow = 1000;

	epoch_tagged_message_queue #(.DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.msg_tow(msg_tow),
		.msg_len(msg_len),
		.more_follows(more_follows),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.found(found),
		.entry_tow(entry_tow),
		.entry_len(entry_len),
		.pushed(pushed),
		.part_status(part_status),
		.entry_count(entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #(PERIOD/2) clk = ~clk;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len(int pct);
		if ($urandom_range(99) >= pct)
			return 0;
		if ($urandom_range(9) == 0)
			return $urandom_range(8, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [LEN_W-1:0] rand_len();
		if ($urandom_range(19) == 0)
			return LEN_W'($urandom_range(0, (1 << LEN_W) - 1));
		return LEN_W'($urandom_range(3, 1026));
	endfunction

	// Entered and left at a falling edge; returns once the transaction is taken.
	task automatic send_item(logic [OP_W-1:0] o, logic [TOW_W-1:0] t,
			logic [LEN_W-1:0] l, logic m);
		int gap;
		gap = gap_len(send_pct);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		msg_tow <= t;
		msg_len <= l;
		more_follows <= m;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_item(o, t, l, m);
		@(negedge clk);
	endtask

	task automatic send_epoch();
		longint nxt;
		logic [TOW_W-1:0] t;
		int parts;
		logic big;
		nxt = cur_tow + $urandom_range(1, 1000);
		if ($urandom_range(49) == 0)
			nxt = $urandom_range(1, 32'(TOW_MAX));
		else if (nxt > TOW_MAX)
			nxt = $urandom_range(1, 1000);
		cur_tow = nxt;
		t = nxt[TOW_W-1:0];
		// An epoch left open is closed first if the new time is not newer, else at random.
		if (sb.open_tow != 0 && (sb.open_tow >= t || $urandom_range(1) == 0))
			send_item(OP_PART, sb.open_tow, rand_len(), 1'b0);
		big = ($urandom_range(24) == 0);
		parts = big ? $urandom_range(35, 45) : $urandom_range(1, 4);
		for (int k = 0; k < parts; k++) begin
			if (k > 0 && t > 1 && $urandom_range(19) == 0)
				send_item(OP_PART, TOW_W'($urandom_range(1, 32'(t) - 1)), rand_len(), 1'b1);
			if (k == parts - 1 && $urandom_range(19) == 0)
				break;
			send_item(OP_PART, t, big ? LEN_W'($urandom_range(1500, 2047)) : rand_len(),
				k != parts - 1);
		end
	endtask

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sb.check_result(found, entry_tow, entry_len, pushed, part_status, entry_count);

	// Receiver: random stalls in phases, plus two long hold-offs that fill the block.
	initial begin
		int left;
		int pct;
		int phase_left;
		int hold_left;
		int next_hold;
		int holds;
		left = 0;
		pct = 0;
		phase_left = 0;
		hold_left = 0;
		next_hold = 300;
		holds = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (phase_left == 0) begin
				phase_left = 150;
				case ($urandom_range(2))
					0: pct = 0;
					1: pct = 25;
					default: pct = 60;
				endcase
			end
			phase_left--;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (holds < 2 && sb.checked >= next_hold) begin
				hold_left = 250;
				next_hold += 800;
				holds++;
				out_stall <= 1'b1;
			end else if (left > 0) begin
				left--;
				out_stall <= 1'b1;
			end else begin
				left = gap_len(pct);
				out_stall <= (left > 0);
				if (left > 0)
					left--;
			end
		end
	end

	initial begin
		int r;
		int n;
		logic [TOW_W-1:0] t;
		in_valid = 1'b0;
		op = OP_PART;
		msg_tow = '0;
		msg_len = '0;
		more_follows = 1'b0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Requests on an empty queue, then a part with a zero time.
		send_item(OP_NEWEST, '0, '0, 1'b0);
		send_item(OP_MATCH, '0, '0, 1'b0);
		send_item(OP_PART, '0, 11'd5, 1'b0);
		// Largest time and length, finished by an empty part.
		send_item(OP_PART, TOW_W'(TOW_MAX), '1, 1'b1);
		send_item(OP_PART, TOW_W'(TOW_MAX), '0, 1'b0);
		// Stale part, then a newer time that discards the open epoch.
		send_item(OP_PART, 30'd100, 11'd1026, 1'b1);
		send_item(OP_PART, 30'd50, 11'd3, 1'b1);
		send_item(OP_PART, 30'd200, 11'd3, 1'b1);
		send_item(OP_PART, 30'd200, 11'd3, 1'b0);
		// Overfill the queue so that the oldest epochs are dropped.
		for (int i = 0; i < DEPTH; i++)
			send_item(OP_PART, TOW_W'(300 + i), LEN_W'(3 + i), 1'b0);
		send_item(OP_MATCH, 30'd303, '0, 1'b0);
		send_item(OP_MATCH, 30'd999, '0, 1'b0);
		send_item(OP_MATCH, '0, '0, 1'b0);
		send_item(OP_UNKNOWN, '1, '1, 1'b1);
		send_item(OP_NEWEST, '0, '0, 1'b0);

		while (sb.accepted < ITEMS) begin
			case ($urandom_range(3))
				0: send_pct = 0;
				1: send_pct = 0;
				2: send_pct = 20;
				default: send_pct = 50;
			endcase
			r = $urandom_range(99);
			if (r < 60) begin
				send_epoch();
			end else if (r < 75) begin
				n = sb.occupied();
				t = (n > 0) ? sb.slot_tow[$urandom_range(0, n - 1)] : cur_tow[TOW_W-1:0];
				send_item(OP_MATCH, t, rand_len(), 1'($urandom_range(1)));
			end else if (r < 83) begin
				send_item(OP_NEWEST, TOW_W'($urandom() & TOW_MAX), rand_len(),
					1'($urandom_range(1)));
			end else if (r < 90) begin
				t = ($urandom_range(3) == 0) ? '0 : TOW_W'($urandom() & TOW_MAX);
				send_item(OP_MATCH, t, rand_len(), 1'($urandom_range(1)));
			end else begin
				t = ($urandom_range(9) == 0) ? '0 : TOW_W'($urandom() & TOW_MAX);
				send_item(OP_W'($urandom_range(3)), t, LEN_W'($urandom_range(0, 2047)),
					1'($urandom_range(1)));
			end
		end
		in_valid <= 1'b0;

		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (2 * DEPTH + 10) @(posedge clk);

		$display("Run covered %0d transactions in and %0d results checked.",
			sb.accepted, sb.checked);
		$display("Epochs queued %0d, requests served %0d, discards %0d, stale parts %0d.",
			sb.n_pushed, sb.n_found, sb.n_discarded, sb.n_stale);
		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#(LIMIT_CYCLES * PERIOD);
		$display("Timeout with %0d results still expected.", sb.outstanding());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
